// ===== design/tsuf_pkg.sv =====
// Shared types, constants and register codes of the time source update filter.
package tsuf_pkg;

	// Field and register widths.
	localparam int SRC_W           = 2;
	localparam int SEC_W           = 32;
	localparam int ADJ_W           = 33;
	localparam int MASK_BITS       = 4;
	localparam int PRIO_W          = 4;
	localparam int PRIO_TABLE_BITS = 16;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_INDEX_W     = 3;

	// Default number of time sources.
	localparam int SOURCES_DEF = 4;

	// Register values after reset.
	localparam logic [CFG_DATA_W-1:0] PREEMPT_RESET   = 16'd60;
	localparam logic [CFG_DATA_W-1:0] GLITCH_RESET    = 16'd10;
	localparam logic [CFG_DATA_W-1:0] IGNORE_RESET    = 16'd10;
	localparam logic [CFG_DATA_W-1:0] MAX_DELAY_RESET = 16'd10;

	// Result codes of one report.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_STALE       = 3'd1,
		ST_GLITCH      = 3'd2,
		ST_PREEMPT     = 3'd3,
		ST_NOT_RUNNING = 3'd4,
		ST_NOT_REG     = 3'd5
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_REGISTERED = 3'd0,
		REG_RUNNING    = 3'd1,
		REG_PRIORITY   = 3'd2,
		REG_PREEMPT    = 3'd3,
		REG_GLITCH     = 3'd4,
		REG_IGNORE     = 3'd5,
		REG_MAX_DELAY  = 3'd6
	} cfg_reg_t;

	// Configuration register contents.
	typedef struct packed {
		logic [MASK_BITS-1:0]       registered_mask;
		logic [MASK_BITS-1:0]       running_mask;
		logic [PRIO_TABLE_BITS-1:0] priority_table;
		logic [CFG_DATA_W-1:0]      preempt_seconds;
		logic [CFG_DATA_W-1:0]      glitch_limit;
		logic [CFG_DATA_W-1:0]      ignore_seconds;
		logic [CFG_DATA_W-1:0]      max_delay_seconds;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic age;
		logic mag;
		logic glitch;
		logic scan;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rejected;
		logic glitched;
		logic preempt_hit;
		logic scan_last;
	} sts_t;

endpackage

// ===== design/tsuf_cfg.sv =====
// Configuration register file of the time source update filter.
module tsuf_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  logic [tsuf_pkg::CFG_INDEX_W-1:0]   index,
	input  logic [tsuf_pkg::CFG_DATA_W-1:0]    data,
	output tsuf_pkg::cfg_t                     cfg
);
	import tsuf_pkg::*;

	cfg_t cfg_q;

	// Register writes, one register per write request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.registered_mask   <= '0;
			cfg_q.running_mask      <= '0;
			cfg_q.priority_table    <= '0;
			cfg_q.preempt_seconds   <= PREEMPT_RESET;
			cfg_q.glitch_limit      <= GLITCH_RESET;
			cfg_q.ignore_seconds    <= IGNORE_RESET;
			cfg_q.max_delay_seconds <= MAX_DELAY_RESET;
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				REG_REGISTERED: cfg_q.registered_mask   <= data[MASK_BITS-1:0];
				REG_RUNNING:    cfg_q.running_mask      <= data[MASK_BITS-1:0];
				REG_PRIORITY:   cfg_q.priority_table    <= data[PRIO_TABLE_BITS-1:0];
				REG_PREEMPT:    cfg_q.preempt_seconds   <= data;
				REG_GLITCH:     cfg_q.glitch_limit      <= data;
				REG_IGNORE:     cfg_q.ignore_seconds    <= data;
				REG_MAX_DELAY:  cfg_q.max_delay_seconds <= data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/tsuf_dp.sv =====
// Datapath of the time source update filter: report registers, per-source state, result.
module tsuf_dp #(
	parameter int NSRC = tsuf_pkg::SOURCES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tsuf_pkg::cfg_t                     cfg,
	input  tsuf_pkg::cmd_t                     cmd,
	output tsuf_pkg::sts_t                     sts,
	input  logic [tsuf_pkg::SRC_W-1:0]         source,
	input  logic [tsuf_pkg::SEC_W-1:0]         remote_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]         local_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]         now_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]         mono_seconds,
	output logic [2:0]                         status,
	output logic                               apply_adjust,
	output logic signed [tsuf_pkg::ADJ_W-1:0]  adjust_seconds
);
	import tsuf_pkg::*;

	localparam int IW = (NSRC > 1) ? $clog2(NSRC) : 1;

	// Report registers.
	logic [SRC_W-1:0] source_q;
	logic [SEC_W-1:0] remote_q;
	logic [SEC_W-1:0] local_q;
	logic [SEC_W-1:0] now_q;
	logic [SEC_W-1:0] mono_q;

	// Intermediate results.
	logic signed [ADJ_W-1:0] delta_q;
	logic [SEC_W-1:0]        mag_q;
	logic                    same_q;
	logic                    rej_q;
	status_t                 rej_code_q;
	logic                    glitched_q;
	logic                    preempt_q;
	logic [PRIO_W-1:0]       mine_q;
	logic [IW-1:0]           cnt_q;

	// Per-source state.
	logic [NSRC-1:0]         rebased_q;
	logic [NSRC-1:0]         glitching_q;
	logic signed [ADJ_W-1:0] gdelta_q [NSRC];
	logic [SEC_W-1:0]        last_q [NSRC];

	// Result registers.
	status_t                 status_q;
	logic                    apply_q;
	logic signed [ADJ_W-1:0] adj_q;

	logic [IW-1:0]           sidx;
	logic                    in_range;
	logic                    not_reg;
	logic                    not_run;
	logic                    future;
	logic                    late;
	logic signed [ADJ_W:0]   diff;
	logic                    big;
	logic                    g_nx;
	logic signed [ADJ_W-1:0] gd_nx;
	logic [1:0]              cidx;
	logic                    hit;
	logic                    ok;
	status_t                 final_st;

	assign sidx     = IW'(source_q);
	assign in_range = int'(source_q) < NSRC;
	assign cidx     = 2'(cnt_q);

	// Admission checks: registration, run state and report age.
	assign not_reg = !in_range || !cfg.registered_mask[source_q];
	assign not_run = !cfg.running_mask[source_q];
	assign future  = now_q < local_q;
	assign late    = {1'b0, now_q} > ({1'b0, local_q} + {17'b0, cfg.max_delay_seconds});

	// Distance of the new delta from the held glitch delta.
	assign diff = (ADJ_W+1)'(delta_q) - (ADJ_W+1)'(gdelta_q[sidx]);

	// Glitch filter: a large delta must repeat, within one second, before it passes.
	always_comb begin
		big   = (mag_q > {16'b0, cfg.glitch_limit}) && rebased_q[sidx];
		g_nx  = 1'b0;
		gd_nx = '0;
		if (big) begin
			if (glitching_q[sidx]) begin
				if (!same_q) begin
					g_nx  = 1'b1;
					gd_nx = delta_q;
				end
			end else begin
				g_nx  = 1'b1;
				gd_nx = delta_q;
			end
		end
	end

	// Preemption test of the source under the scan counter.
	assign hit = (cnt_q != sidx) && cfg.registered_mask[cidx] &&
		(cfg.priority_table[{cidx, 2'b00} +: PRIO_W] > mine_q) && rebased_q[cnt_q] &&
		({1'b0, mono_q} < ({1'b0, last_q[cnt_q]} + {17'b0, cfg.preempt_seconds}));

	// Final verdict of the report.
	always_comb begin
		priority if (rej_q)      final_st = rej_code_q;
		else if (glitched_q)     final_st = ST_GLITCH;
		else if (preempt_q)      final_st = ST_PREEMPT;
		else                     final_st = ST_OK;
	end
	assign ok = (final_st == ST_OK);

	// Report capture and working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			source_q <= source;
			remote_q <= remote_seconds;
			local_q  <= local_seconds;
			now_q    <= now_seconds;
			mono_q   <= mono_seconds;
		end
		if (cmd.age) begin
			delta_q <= {1'b0, remote_q} - {1'b0, local_q};
			rej_q   <= not_reg || not_run || future || late;
			priority if (not_reg)  rej_code_q <= ST_NOT_REG;
			else if (not_run)      rej_code_q <= ST_NOT_RUNNING;
			else                   rej_code_q <= ST_STALE;
		end
		if (cmd.mag) begin
			mag_q  <= delta_q[ADJ_W-1] ? SEC_W'(-delta_q) : delta_q[SEC_W-1:0];
			same_q <= (diff == '0) || (diff == (ADJ_W+1)'(1)) || (diff == '1);
		end
		if (cmd.glitch) begin
			glitched_q <= g_nx;
			mine_q     <= cfg.priority_table[{source_q, 2'b00} +: PRIO_W];
		end
		if (cmd.finish) begin
			status_q <= final_st;
			apply_q  <= ok && (mag_q > {16'b0, cfg.ignore_seconds});
			adj_q    <= (ok && (mag_q > {16'b0, cfg.ignore_seconds})) ? delta_q : '0;
		end
	end

	// Scan counter and preemption flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			preempt_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q     <= '0;
			preempt_q <= 1'b0;
		end else if (cmd.scan) begin
			cnt_q <= cnt_q + IW'(1);
			if (hit) begin
				preempt_q <= 1'b1;
			end
		end
	end

	// Per-source state: glitch filter and sync record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rebased_q   <= '0;
			glitching_q <= '0;
			for (int i = 0; i < NSRC; i++) begin
				gdelta_q[i] <= '0;
				last_q[i]   <= '0;
			end
		end else begin
			if (cmd.glitch && !rej_q) begin
				glitching_q[sidx] <= g_nx;
				gdelta_q[sidx]    <= gd_nx;
			end
			if (cmd.finish && ok) begin
				rebased_q[sidx] <= 1'b1;
				last_q[sidx]    <= mono_q;
			end
		end
	end

	assign sts.rejected    = rej_q;
	assign sts.glitched    = g_nx;
	assign sts.preempt_hit = hit;
	assign sts.scan_last   = (cnt_q == IW'(NSRC - 1));

	assign status         = status_q;
	assign apply_adjust   = apply_q;
	assign adjust_seconds = adj_q;

	// An adjustment is zero unless it is applied.
	a_adj_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (apply_q || adj_q == '0))
		else $error("adjustment nonzero without apply");

	// A preemption hit in the scan is remembered.
	a_preempt_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan && hit |=> preempt_q)
		else $error("preemption hit lost");

	// A rejected report never shifts the time.
	a_reject_no_apply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && rej_q |=> !apply_q)
		else $error("adjustment applied for a rejected report");

endmodule

// ===== design/tsuf_ctrl.sv =====
// Controller of the time source update filter: sequencing and handshakes.
module tsuf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output tsuf_pkg::cmd_t  cmd,
	input  tsuf_pkg::sts_t  sts
);
	import tsuf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AGE,
		S_MAG,
		S_GLITCH,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Commands for the datapath.
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.age    = (state_q == S_AGE);
		cmd.mag    = (state_q == S_MAG);
		cmd.glitch = (state_q == S_GLITCH);
		cmd.scan   = (state_q == S_SCAN);
		cmd.finish = (state_q == S_FINISH) && out_free;
	end

	// State sequence and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_AGE;
					end
				end
				S_AGE: state_q <= S_MAG;
				S_MAG: state_q <= S_GLITCH;
				S_GLITCH: begin
					if (sts.rejected || sts.glitched) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.preempt_hit || sts.scan_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// An accepted request keeps the input side busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not held off after accept");

	// A finished result shows up as valid.
	a_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished result not valid");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && out_valid_q && out_stall |=> state_q == S_FINISH)
		else $error("result overwritten while stalled");

endmodule

// ===== design/time_source_update_filter_unit.sv =====
// Top level of the time source update filter.
// Each request is one time report; it yields exactly one result with a status,
// an apply flag and the signed seconds adjustment. A report is taken only while
// the block is idle. A rejected or glitched report goes from the age, magnitude
// and glitch steps straight to the finish step; a report that reaches the priority
// check also passes the scan, in which the last-sync times of the other
// sources are checked one per cycle through a single adder and comparator (the
// scan stops at the first preempting source). The result waits in an output
// register, so the next report is accepted while it is still stalled.
module time_source_update_filter_unit #(
	parameter int SOURCES = tsuf_pkg::SOURCES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tsuf_pkg::SRC_W-1:0]         source,
	input  logic [tsuf_pkg::SEC_W-1:0]         remote_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]         local_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]         now_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]         mono_seconds,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic                               apply_adjust,
	output logic signed [tsuf_pkg::ADJ_W-1:0]  adjust_seconds,
	input  logic                               cfg_write,
	input  logic [tsuf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tsuf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tsuf_pkg::*;

	// Only sources within the mask width can ever be registered.
	localparam int NSRC = (SOURCES < MASK_BITS) ? SOURCES : MASK_BITS;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	tsuf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_write),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tsuf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	tsuf_dp #(
		.NSRC (NSRC)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.source         (source),
		.remote_seconds (remote_seconds),
		.local_seconds  (local_seconds),
		.now_seconds    (now_seconds),
		.mono_seconds   (mono_seconds),
		.status         (status),
		.apply_adjust   (apply_adjust),
		.adjust_seconds (adjust_seconds)
	);

endmodule

// ===== sim/tsuf_result_checker.sv =====
`timescale 1ns / 1ps
// Watches the filter's channels, predicts each report's verdict and compares the results.
module tsuf_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [tsuf_pkg::SRC_W-1:0]        source,
	input  logic [tsuf_pkg::SEC_W-1:0]        remote_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]        local_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]        now_seconds,
	input  logic [tsuf_pkg::SEC_W-1:0]        mono_seconds,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [2:0]                        status,
	input  logic                              apply_adjust,
	input  logic signed [tsuf_pkg::ADJ_W-1:0] adjust_seconds,
	input  logic                              cfg_write,
	input  logic [tsuf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tsuf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                errors,
	output int                                pending
);
	import tsuf_pkg::*;

	localparam int NSRC = 4;

	typedef struct packed {
		status_t          st;
		logic             apply;
		logic [ADJ_W-1:0] adj;
	} verdict_t;

	// Shadow copy of the registers.
	logic [MASK_BITS-1:0]       reg_mask;
	logic [MASK_BITS-1:0]       run_mask;
	logic [PRIO_TABLE_BITS-1:0] prio_table;
	logic [CFG_DATA_W-1:0]      preempt_s;
	logic [CFG_DATA_W-1:0]      glitch_s;
	logic [CFG_DATA_W-1:0]      ignore_s;
	logic [CFG_DATA_W-1:0]      max_delay_s;

	// Shadow copy of the per-source sync and glitch state.
	logic        rebased [NSRC];
	logic [31:0] last_mono [NSRC];
	logic        glitching [NSRC];
	longint      held_delta [NSRC];

	verdict_t pending_verdicts [$];
	int       fails;

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Works out the verdict of one report and advances the shadow state.
	function automatic verdict_t judge_report(input logic [1:0] src, input logic [31:0] rem,
			input logic [31:0] loc, input logic [31:0] nw, input logic [31:0] mn);
		longint   delta;
		longint   age;
		longint   since;
		int       mine;
		int       i;
		verdict_t v;
		delta = longint'(rem) - longint'(loc);
		age = longint'(nw) - longint'(loc);
		v.st = ST_OK;
		v.apply = 1'b0;
		v.adj = '0;
		if (!reg_mask[src]) begin
			v.st = ST_NOT_REG;
		end else if (!run_mask[src]) begin
			v.st = ST_NOT_RUNNING;
		end else if (age < 0 || age > longint'(max_delay_s)) begin
			v.st = ST_STALE;
		end else begin
			// A large delta after the first rebase must be seen twice.
			if (magnitude(delta) > longint'(glitch_s) && rebased[src]) begin
				if (glitching[src]) begin
					if (magnitude(delta - held_delta[src]) <= 1) begin
						glitching[src] = 1'b0;
						held_delta[src] = 0;
					end else begin
						held_delta[src] = delta;
					end
				end else begin
					glitching[src] = 1'b1;
					held_delta[src] = delta;
				end
			end else begin
				glitching[src] = 1'b0;
				held_delta[src] = 0;
			end

			if (glitching[src]) begin
				v.st = ST_GLITCH;
			end else begin
				// A recent sync of a registered higher-priority source holds this one off.
				mine = int'(prio_table[4*src +: 4]);
				for (i = 0; i < NSRC; i++) begin
					if (i != src && v.st == ST_OK && reg_mask[i] && rebased[i] &&
							int'(prio_table[4*i +: 4]) > mine) begin
						since = longint'(mn) - longint'(last_mono[i]);
						if (since < longint'(preempt_s))
							v.st = ST_PREEMPT;
					end
				end
				if (v.st == ST_OK) begin
					rebased[src] = 1'b1;
					last_mono[src] = mn;
					if (magnitude(delta) > longint'(ignore_s)) begin
						v.apply = 1'b1;
						v.adj = delta[ADJ_W-1:0];
					end
				end
			end
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			reg_mask = '0;
			run_mask = '0;
			prio_table = '0;
			preempt_s = PREEMPT_RESET;
			glitch_s = GLITCH_RESET;
			ignore_s = IGNORE_RESET;
			max_delay_s = MAX_DELAY_RESET;
			for (int k = 0; k < NSRC; k++) begin
				rebased[k] = 1'b0;
				last_mono[k] = '0;
				glitching[k] = 1'b0;
				held_delta[k] = 0;
			end
			pending_verdicts.delete();
			fails = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// Register writes.
			if (cfg_write) begin
				case (cfg_index)
					REG_REGISTERED: reg_mask = cfg_data[MASK_BITS-1:0];
					REG_RUNNING:    run_mask = cfg_data[MASK_BITS-1:0];
					REG_PRIORITY:   prio_table = cfg_data;
					REG_PREEMPT:    preempt_s = cfg_data;
					REG_GLITCH:     glitch_s = cfg_data;
					REG_IGNORE:     ignore_s = cfg_data;
					REG_MAX_DELAY:  max_delay_s = cfg_data;
					default: ;
				endcase
			end

			// Results are compared against the oldest prediction.
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					if (fails < 10)
						$display("unexpected result: status %0d apply %0b adjust %0d",
							status, apply_adjust, adjust_seconds);
					fails++;
				end else begin
					want = pending_verdicts.pop_front();
					if (status !== want.st || apply_adjust !== want.apply ||
							adjust_seconds !== want.adj) begin
						if (fails < 10)
							$display("mismatch at %0t: expected status %0d ",
								$realtime, want.st,
								"apply %0b adjust %0d, ",
								want.apply, $signed(want.adj),
								"got status %0d apply %0b adjust %0d",
								status, apply_adjust, adjust_seconds);
						fails++;
					end
				end
			end

			// Each accepted request is predicted at once.
			if (in_valid && !in_stall)
				pending_verdicts.push_back(judge_report(source, remote_seconds,
					local_seconds, now_seconds, mono_seconds));

			errors <= fails;
			pending <= pending_verdicts.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the time source update filter.
module tb;
	import tsuf_pkg::*;

	localparam int ITEMS_PER_PHASE = 118;
	localparam int PHASES          = 8;
	localparam int HOLD_CYCLES     = 400;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [SRC_W-1:0]            source;
	logic [SEC_W-1:0]            remote_seconds;
	logic [SEC_W-1:0]            local_seconds;
	logic [SEC_W-1:0]            now_seconds;
	logic [SEC_W-1:0]            mono_seconds;
	logic                        out_valid;
	logic                        out_stall;
	logic [2:0]                  status;
	logic                        apply_adjust;
	logic signed [ADJ_W-1:0]     adjust_seconds;
	logic                        cfg_write;
	logic [CFG_INDEX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	int                          errors;
	int                          pending;

	idle_mode_t idle_mode = IDLE_NONE;
	bit         hold_asked = 1'b0;
	int         hold_left = 0;

	// Current settings, used only to shape the random reports.
	int          cur_preempt;
	int          cur_glitch;
	int          cur_ignore;
	int          cur_delay;
	logic [31:0] mono_clock;
	longint      big_delta [4];
	bit          big_seen [4];

	always #5 clk = ~clk;

	time_source_update_filter_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.source(source), .remote_seconds(remote_seconds), .local_seconds(local_seconds),
		.now_seconds(now_seconds), .mono_seconds(mono_seconds),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .apply_adjust(apply_adjust), .adjust_seconds(adjust_seconds),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tsuf_result_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.source(source), .remote_seconds(remote_seconds), .local_seconds(local_seconds),
		.now_seconds(now_seconds), .mono_seconds(mono_seconds),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .apply_adjust(apply_adjust), .adjust_seconds(adjust_seconds),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	// Receiver: random stalls per mode, plus a long hold-off when one is asked for.
	initial begin
		int pct;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			pct = (idle_mode == IDLE_RECEIVER) ? 54 : (idle_mode == IDLE_BOTH) ? 13 : 0;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_asked) begin
				hold_asked = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < pct);
			end
		end
	end

	// Offers one report and returns at the edge that takes it.
	task automatic send_report(input logic [1:0] src, input logic [31:0] rem,
			input logic [31:0] loc, input logic [31:0] nw, input logic [31:0] mn);
		int pct;
		pct = (idle_mode == IDLE_SENDER) ? 54 : (idle_mode == IDLE_BOTH) ? 13 : 0;
		while ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		source <= src;
		remote_seconds <= rem;
		local_seconds <= loc;
		now_seconds <= nw;
		mono_seconds <= mn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stops offering and waits until every result is back and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Writes all seven registers; the block must be idle.
	task automatic load_settings(input logic [3:0] regm, input logic [3:0] runm,
			input logic [15:0] prio, input logic [15:0] pre, input logic [15:0] gl,
			input logic [15:0] ig, input logic [15:0] md);
		put_reg(REG_REGISTERED, {12'd0, regm});
		put_reg(REG_RUNNING, {12'd0, runm});
		put_reg(REG_PRIORITY, prio);
		put_reg(REG_PREEMPT, pre);
		put_reg(REG_GLITCH, gl);
		put_reg(REG_IGNORE, ig);
		put_reg(REG_MAX_DELAY, md);
		cfg_write <= 1'b0;
		cur_preempt = int'(pre);
		cur_glitch = int'(gl);
		cur_ignore = int'(ig);
		cur_delay = int'(md);
	endtask

	// One random report: mostly fresh reports with chosen deltas, some noise.
	task automatic rand_report();
		int          r;
		longint      delta;
		longint      mag_d;
		longint      lo;
		longint      span;
		longint      age;
		logic [1:0]  src;
		logic [31:0] loc;
		logic [31:0] rem;
		logic [31:0] nw;
		src = 2'($urandom_range(3));
		if ($urandom_range(99) < 8) begin
			send_report(src, $urandom, $urandom, $urandom, $urandom);
		end else begin
			// Delta: a repeat of a held glitch, small, medium, large or huge.
			r = $urandom_range(99);
			if (big_seen[src] && r < 30) begin
				delta = big_delta[src] + longint'($urandom_range(4)) - 2;
			end else begin
				if (r < 55)
					delta = longint'($urandom_range(cur_ignore));
				else if (r < 70 && cur_glitch > cur_ignore)
					delta = cur_ignore + 1 + longint'($urandom_range(cur_glitch - cur_ignore - 1));
				else if (r < 70)
					delta = longint'($urandom_range(cur_glitch + 20));
				else if (r < 92)
					delta = cur_glitch + 1 + longint'($urandom_range(100000));
				else
					delta = longint'({32'd0, $urandom});
				if ($urandom_range(1))
					delta = -delta;
				if (r >= 70) begin
					big_delta[src] = delta;
					big_seen[src] = 1'b1;
				end
			end
			if (delta > 64'sh0_FFFF_FFFF)
				delta = 64'sh0_FFFF_FFFF;
			if (delta < -64'sh0_FFFF_FFFF)
				delta = -64'sh0_FFFF_FFFF;

			// Collection time chosen so that the remote time does not wrap.
			mag_d = (delta < 0) ? -delta : delta;
			span = 64'sh0_FFFF_FFFF - mag_d;
			lo = (delta < 0) ? -delta : 0;
			loc = 32'(lo + longint'($urandom_range(32'(span))));
			rem = 32'(longint'(loc) + delta);

			// Report age: mostly fresh, sometimes at the limit, stale or in the future.
			r = $urandom_range(99);
			if (r < 78)
				age = longint'($urandom_range(cur_delay));
			else if (r < 84)
				age = longint'(cur_delay);
			else if (r < 92)
				age = cur_delay + 1 + longint'($urandom_range(5));
			else
				age = -1 - longint'($urandom_range(5));
			nw = 32'(longint'(loc) + age);

			// Monotonic clock: mostly forward, sometimes backward or anywhere.
			r = $urandom_range(99);
			if (r < 90)
				mono_clock = mono_clock + $urandom_range(cur_preempt / 3 + 2);
			else if (r < 96)
				mono_clock = mono_clock - $urandom_range(30);
			else
				mono_clock = $urandom;
			send_report(src, rem, loc, nw, mono_clock);
		end
	endtask

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		source <= '0;
		remote_seconds <= '0;
		local_seconds <= '0;
		now_seconds <= '0;
		mono_seconds <= '0;
		cfg_write <= 1'b0;
		cfg_index <= REG_REGISTERED;
		cfg_data <= '0;
		cur_preempt = int'(PREEMPT_RESET);
		cur_glitch = int'(GLITCH_RESET);
		cur_ignore = int'(IGNORE_RESET);
		cur_delay = int'(MAX_DELAY_RESET);
		mono_clock = '0;
		for (int k = 0; k < 4; k++) begin
			big_delta[k] = 0;
			big_seen[k] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing is registered after reset.
		send_report(2'd0, 32'd1003, 32'd1000, 32'd1000, 32'd5);
		send_report(2'd3, 32'd1003, 32'd1000, 32'd1000, 32'd5);
		settle();

		// Source 2 unregistered, source 3 stopped, source 1 outranks source 0.
		load_settings(4'b1011, 4'b0011, 16'h0052, 16'd60, 16'd10, 16'd5, 16'd10);
		send_report(2'd2, 32'd1000, 32'd1000, 32'd1000, 32'd10);
		send_report(2'd3, 32'd1000, 32'd1000, 32'd1000, 32'd10);
		// Collected in the future, then one second too old, then exactly at the limit.
		send_report(2'd0, 32'd1003, 32'd1000, 32'd999, 32'd100);
		send_report(2'd0, 32'd1003, 32'd1000, 32'd1011, 32'd100);
		send_report(2'd0, 32'd1003, 32'd1000, 32'd1010, 32'd100);
		// Large delta held back, then confirmed within one second.
		send_report(2'd0, 32'd2000, 32'd1000, 32'd1000, 32'd101);
		send_report(2'd0, 32'd2001, 32'd1000, 32'd1000, 32'd101);
		// Negative glitch, a repeat off by two, then one within tolerance.
		send_report(2'd0, 32'd500, 32'd1000, 32'd1000, 32'd102);
		send_report(2'd0, 32'd498, 32'd1000, 32'd1000, 32'd102);
		send_report(2'd0, 32'd497, 32'd1000, 32'd1000, 32'd102);
		// The higher-priority source syncs and then holds off the lower one.
		send_report(2'd1, 32'd1007, 32'd1000, 32'd1005, 32'd110);
		send_report(2'd0, 32'd1006, 32'd1000, 32'd1000, 32'd120);
		// A glitch while held off still arms the filter.
		send_report(2'd0, 32'd1050, 32'd1000, 32'd1000, 32'd120);
		send_report(2'd0, 32'd1050, 32'd1000, 32'd1000, 32'd200);
		// Monotonic time going backwards, then the hold-off boundary.
		send_report(2'd0, 32'd1000, 32'd1000, 32'd1000, 32'd105);
		send_report(2'd0, 32'd1000, 32'd1000, 32'd1000, 32'd169);
		send_report(2'd0, 32'd1000, 32'd1000, 32'd1000, 32'd170);
		// Extreme deltas in both directions.
		send_report(2'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd300);
		send_report(2'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd300);
		send_report(2'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_report(2'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Delta exactly at the ignore threshold, then one above it.
		send_report(2'd1, 32'd5, 32'd0, 32'd0, 32'd0);
		send_report(2'd1, 32'd0, 32'd6, 32'd6, 32'd0);
		settle();

		// Random phases over several settings and idle patterns.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: load_settings(4'hF, 4'hF, 16'h4321, 16'd20, 16'd10, 16'd3, 16'd10);
				1: load_settings(4'hF, 4'hF, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0);
				2: load_settings(4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: load_settings(4'hF, 4'hF, 16'h1234, 16'd0, 16'd4, 16'd2, 16'd3);
				default: begin
					int gl;
					gl = $urandom_range(50);
					load_settings(($urandom_range(2) == 0) ? 4'($urandom) : 4'hF,
						($urandom_range(2) == 0) ? 4'($urandom) : 4'hF,
						16'($urandom), 16'($urandom_range(200)), 16'(gl),
						16'($urandom_range(gl + 5)), 16'($urandom_range(30)));
				end
			endcase
			idle_mode = idle_mode_t'(p % 4);
			if (p == 1 || p == 5)
				hold_asked = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				rand_report();
			settle();
		end

		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
